/* rtl/xc2p16_pkg.sv */
// ----------------------------------------------------------------------------
// xc2p16_pkg: types and tables for the palette-16 colour mapper
// Request and result words, the sixteen palette entries, the ANSI to
// machine table and small helper functions shared by the mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package xc2p16_pkg;

    localparam int NumEntries = 16;
    localparam int EntryBits  = $clog2(NumEntries);
    localparam int DistBits   = 16;
    localparam int QsqBits    = 14;

    localparam logic [7:0] GreyBase = 8'd232;
    localparam logic [7:0] CubeBase = 8'd16;
    localparam logic [7:0] AnsiTop  = 8'd16;
    localparam logic [7:0] IndexMax = 8'd255;

    typedef struct packed {
        logic        command;
        logic [15:0] colour_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } request_t;

    typedef struct packed {
        logic [4:0] colour_value;
        logic [3:0] machine_colour;
    } result_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef struct packed {
        logic [DistBits-1:0]  cost;
        logic [EntryBits-1:0] idx;
    } cand_t;

    localparam rgb_t Palette [NumEntries] = '{
        '{8'd0,   8'd0,   8'd0  }, '{8'd255, 8'd255, 8'd255},
        '{8'd136, 8'd0,   8'd0  }, '{8'd170, 8'd255, 8'd238},
        '{8'd204, 8'd68,  8'd204}, '{8'd0,   8'd204, 8'd85 },
        '{8'd0,   8'd0,   8'd170}, '{8'd238, 8'd238, 8'd119},
        '{8'd221, 8'd136, 8'd85 }, '{8'd102, 8'd68,  8'd0  },
        '{8'd255, 8'd119, 8'd119}, '{8'd51,  8'd51,  8'd51 },
        '{8'd119, 8'd119, 8'd119}, '{8'd170, 8'd255, 8'd102},
        '{8'd0,   8'd136, 8'd255}, '{8'd187, 8'd187, 8'd187}
    };

    localparam logic [3:0] AnsiToMachine [16] = '{
        4'd0, 4'd2, 4'd5, 4'd7, 4'd6, 4'd4, 4'd3, 4'd15,
        4'd11, 4'd10, 4'd13, 4'd7, 4'd14, 4'd4, 4'd3, 4'd1
    };

    // 6x6x6 cube channel level: 0, or 55 + 40v
    function automatic logic [7:0] cube_level(input logic [2:0] v);
        logic [7:0] lvl;
        lvl = (v == 3'd0) ? 8'd0 : 8'd55 + 8'(v) * 8'd40;
        return lvl;
    endfunction

    // squared channel difference, quartered
    function automatic logic [QsqBits-1:0] quarter_sq(input logic [7:0] p,
                                                      input logic [7:0] q);
        logic [7:0]  d;
        logic [15:0] sq;
        d  = (p > q) ? (p - q) : (q - p);
        sq = 16'(d) * 16'(d);
        return sq[15:2];
    endfunction

    // lower index wins a tie
    function automatic cand_t pick_min(input cand_t a, input cand_t b);
        cand_t w;
        w = (b.cost < a.cost) ? b : a;
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/xterm_colour_to_palette16.sv */
// ----------------------------------------------------------------------------
// xterm_colour_to_palette16: terminal colour to 16-entry machine palette
// Decodes an xterm index or takes an RGB triple, finds the nearest of the
// sixteen palette entries and returns the colour value and machine colour.
//
//   port     dir  width  role
//   start    in   1      request strobe, word taken when busy is low
//   request  in   41     command, colour_index, red, green, blue
//   busy     out  1      always low, a word is taken every cycle
//   done     out  1      result strobe, high for one cycle
//   result   out  9      colour_value, machine_colour
//
// One word per clock, sustained. The stages, in order: input register,
// index decode, distance squarers, 16-to-4 minimum tree, then 4-to-1
// minimum into the result register. Reset clears only the valid bits of
// the pipeline. The receiver cannot stall, so nothing is held.
// ----------------------------------------------------------------------------
`default_nettype none

module xterm_colour_to_palette16
    import xc2p16_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire request_t request,
    output logic          busy,
    output logic          done,
    output result_t       result
);

    localparam int Groups = NumEntries / 4;

    // stage 0: input word
    logic     v0_reg;
    request_t req_reg;

    // stage 1: decoded colour
    logic       v1_reg;
    logic       pass1_reg;
    logic [3:0] ansi1_reg;
    rgb_t       rgb1_reg;

    // stage 2: distances
    logic                v2_reg;
    logic                pass2_reg;
    logic [3:0]          ansi2_reg;
    logic [DistBits-1:0] dist2_reg [NumEntries];

    // stage 3: best of each group of four
    logic       v3_reg;
    logic       pass3_reg;
    logic [3:0] ansi3_reg;
    cand_t      grp3_reg [Groups];

    // stage 4: result
    logic    done_reg;
    result_t result_reg;

    logic [7:0] n8;
    logic       pass_next;
    logic [4:0] grey_off;
    logic [7:0] grey_lvl;
    logic [7:0] cube_x;
    logic [2:0] rd, gd, bd;
    logic [5:0] rem36;
    rgb_t       rgb_next;

    logic [DistBits-1:0] dist_next [NumEntries];
    cand_t               grp_next [Groups];
    cand_t               best_next;
    result_t             result_next;

    assign busy = 1'b0;

    // index decode
    always_comb
    begin
        n8        = (req_reg.colour_index > 16'(IndexMax)) ?
                    IndexMax : req_reg.colour_index[7:0];
        pass_next = !req_reg.command && (n8 < AnsiTop);
        grey_off  = 5'(n8 - GreyBase);
        grey_lvl  = 8'd8 + 8'(grey_off) * 8'd10;
        cube_x    = n8 - CubeBase;
        rd = 3'd0;
        for (int k = 1; k < 6; k++)
        begin
            if (cube_x >= 8'(36 * k))
                rd = 3'(k);
        end
        rem36 = 6'(cube_x - 8'(rd) * 8'd36);
        gd = 3'd0;
        for (int k = 1; k < 6; k++)
        begin
            if (rem36 >= 6'(6 * k))
                gd = 3'(k);
        end
        bd = 3'(rem36 - 6'(gd) * 6'd6);
        if (req_reg.command)
            rgb_next = '{req_reg.red, req_reg.green, req_reg.blue};
        else if (n8 >= GreyBase)
            rgb_next = '{grey_lvl, grey_lvl, grey_lvl};
        else
            rgb_next = '{cube_level(rd), cube_level(gd), cube_level(bd)};
    end

    // distance to every entry, green counted twice
    always_comb
    begin
        for (int k = 0; k < NumEntries; k++)
        begin
            dist_next[k] = 16'(quarter_sq(rgb1_reg.r, Palette[k].r))
                         + 16'({quarter_sq(rgb1_reg.g, Palette[k].g), 1'b0})
                         + 16'(quarter_sq(rgb1_reg.b, Palette[k].b));
        end
    end

    // first level of the minimum tree
    always_comb
    begin
        for (int g = 0; g < Groups; g++)
        begin
            grp_next[g] = pick_min(
                pick_min('{dist2_reg[4*g],   EntryBits'(4*g)},
                         '{dist2_reg[4*g+1], EntryBits'(4*g+1)}),
                pick_min('{dist2_reg[4*g+2], EntryBits'(4*g+2)},
                         '{dist2_reg[4*g+3], EntryBits'(4*g+3)}));
        end
    end

    // final minimum and result
    always_comb
    begin
        best_next = grp3_reg[0];
        for (int g = 1; g < Groups; g++)
            best_next = pick_min(best_next, grp3_reg[g]);
        if (pass3_reg)
        begin
            result_next.colour_value   = {1'b0, ansi3_reg};
            result_next.machine_colour = AnsiToMachine[ansi3_reg];
        end
        else
        begin
            result_next.colour_value   = {1'b1, best_next.idx};
            result_next.machine_colour = best_next.idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start && !busy;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // payload advances every cycle, no reset
    always_ff @(posedge clk)
    begin
        req_reg    <= request;
        pass1_reg  <= pass_next;
        ansi1_reg  <= n8[3:0];
        rgb1_reg   <= rgb_next;
        pass2_reg  <= pass1_reg;
        ansi2_reg  <= ansi1_reg;
        dist2_reg  <= dist_next;
        pass3_reg  <= pass2_reg;
        ansi3_reg  <= ansi2_reg;
        grp3_reg   <= grp_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 5))
        else $error("done without a word taken five cycles before");

    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##5 done)
        else $error("accepted word produced no result");

    a_machine_match: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.colour_value[4] |->
            result.machine_colour == result.colour_value[3:0])
        else $error("palette result with mismatched machine colour");

    a_truecolor_entry: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !pass1_reg |=> !pass2_reg)
        else $error("decoded colour lost its palette path");

endmodule

`default_nettype wire

/* bench/palette16_result_checker.sv */
// ----------------------------------------------------------------------------
// palette16_result_checker: scoreboard for the palette-16 colour mapper
// Watches the request and result channels. It computes the expected colour
// value and machine colour for each accepted request word, and compares
// every result word field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module palette16_result_checker
    import xc2p16_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    input  logic     busy,
    input  logic     done,
    input  result_t  result,
    output int       failures,
    output int       pending
);

    result_t awaited_results [$];
    result_t oldest;

    function automatic logic [23:0] entry_rgb(input int k);
        logic [23:0] rgb;
        case (k)
            0:       rgb = 24'h000000;
            1:       rgb = 24'hffffff;
            2:       rgb = 24'h880000;
            3:       rgb = 24'haaffee;
            4:       rgb = 24'hcc44cc;
            5:       rgb = 24'h00cc55;
            6:       rgb = 24'h0000aa;
            7:       rgb = 24'heeee77;
            8:       rgb = 24'hdd8855;
            9:       rgb = 24'h664400;
            10:      rgb = 24'hff7777;
            11:      rgb = 24'h333333;
            12:      rgb = 24'h777777;
            13:      rgb = 24'haaff66;
            14:      rgb = 24'h0088ff;
            default: rgb = 24'hbbbbbb;
        endcase
        return rgb;
    endfunction

    function automatic logic [3:0] ansi_machine(input int ansi);
        logic [3:0] mc;
        case (ansi)
            0:       mc = 4'd0;
            1:       mc = 4'd2;
            2:       mc = 4'd5;
            3:       mc = 4'd7;
            4:       mc = 4'd6;
            5:       mc = 4'd4;
            6:       mc = 4'd3;
            7:       mc = 4'd15;
            8:       mc = 4'd11;
            9:       mc = 4'd10;
            10:      mc = 4'd13;
            11:      mc = 4'd7;
            12:      mc = 4'd14;
            13:      mc = 4'd4;
            14:      mc = 4'd3;
            default: mc = 4'd1;
        endcase
        return mc;
    endfunction

    function automatic int quarter_square(input int a, input int b);
        int d;
        d = (a > b) ? a - b : b - a;
        return (d * d) >> 2;
    endfunction

    // green weighs double; strict compare keeps the lowest entry on a tie
    function automatic int nearest_entry(input int r, input int g, input int b);
        int best;
        int pick;
        int cost;
        logic [23:0] rgb;
        best = 'hffff;
        pick = 0;
        for (int k = 0; k < 16; k++)
        begin
            rgb  = entry_rgb(k);
            cost = quarter_square(r, rgb[23:16]) + 2 * quarter_square(g, rgb[15:8])
                 + quarter_square(b, rgb[7:0]);
            if (cost < best)
            begin
                best = cost;
                pick = k;
            end
        end
        return pick;
    endfunction

    function automatic int cube_channel(input int v);
        return (v == 0) ? 0 : 55 + 40 * v;
    endfunction

    function automatic result_t map_request(input request_t req);
        result_t mapped;
        int      n;
        int      x;
        int      grey;
        int      value;
        if (req.command)
            value = 16 + nearest_entry(req.red, req.green, req.blue);
        else
        begin
            n = req.colour_index;
            if (n < 16)
                value = n;
            else
            begin
                if (n > 255)
                    n = 255;
                if (n >= 232)
                begin
                    grey  = 8 + 10 * (n - 232);
                    value = 16 + nearest_entry(grey, grey, grey);
                end
                else
                begin
                    x     = n - 16;
                    value = 16 + nearest_entry(cube_channel(x / 36),
                                               cube_channel((x / 6) % 6),
                                               cube_channel(x % 6));
                end
            end
        end
        mapped.colour_value   = 5'(value);
        mapped.machine_colour = (value >= 16) ? 4'(value - 16) : ansi_machine(value);
        return mapped;
    endfunction

    task automatic report(input string line);
        $display("ERROR: %s", line);
        failures++;
    endtask

    initial
    begin
        failures = 0;
        pending  = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                    report($sformatf("result word %0d/%0d with no request waiting",
                                     result.colour_value, result.machine_colour));
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (result.colour_value !== oldest.colour_value)
                        report($sformatf("colour_value got %0d, expected %0d",
                                         result.colour_value, oldest.colour_value));
                    if (result.machine_colour !== oldest.machine_colour)
                        report($sformatf("machine_colour got %0d, expected %0d",
                                         result.machine_colour, oldest.machine_colour));
                end
            end
            if (start && !busy)
                awaited_results.push_back(map_request(request));
            pending = awaited_results.size();
        end
    end

endmodule

/* bench/xterm_colour_to_palette16_test.sv */
// ----------------------------------------------------------------------------
// xterm_colour_to_palette16_test: top of the colour mapper testbench
// Drives directed and random colour requests, indexed and truecolor, with
// random idle bursts on the request side, and gives the verdict from the
// failure count of the result checker.
// ----------------------------------------------------------------------------
module xterm_colour_to_palette16_test;
    import xc2p16_pkg::*;

    localparam logic CmdIndexed   = 1'b0;
    localparam logic CmdTruecolor = 1'b1;

    localparam int RandomWords   = 400;
    localparam int SteadyTail    = 60;
    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 12;

    logic     clk;
    logic     rst_n;
    logic     start;
    request_t request;
    logic     busy;
    logic     done;
    result_t  result;
    int       failures;
    int       pending;
    int       stall_cycles;

    xterm_colour_to_palette16 dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    palette16_result_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // unused fields carry random garbage
    function automatic request_t make_index(input int n);
        request_t word;
        word.command      = CmdIndexed;
        word.colour_index = 16'(n);
        word.red          = 8'($urandom);
        word.green        = 8'($urandom);
        word.blue         = 8'($urandom);
        return word;
    endfunction

    function automatic request_t make_rgb(input int r, input int g, input int b);
        request_t word;
        word.command      = CmdTruecolor;
        word.colour_index = 16'($urandom);
        word.red          = 8'(r);
        word.green        = 8'(g);
        word.blue         = 8'(b);
        return word;
    endfunction

    // idle for gap cycles, then hold the word until it is taken
    task automatic send_word(input request_t word, input int gap);
        if (gap > 0)
        begin
            @(negedge clk) start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic int pick_gap(input bit allow);
        return (allow && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    endfunction

    function automatic request_t random_word();
        request_t word;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: word = make_index($urandom_range(16, 255));
            4:          word = make_index($urandom_range(0, 15));
            5:          word = make_index($urandom_range(0, 65535));
            6, 7, 8:    word = make_rgb($urandom_range(0, 255), $urandom_range(0, 255),
                                        $urandom_range(0, 255));
            // dark colours near the black/dark grey boundary, where ties occur
            default:    word = make_rgb($urandom_range(15, 35), $urandom_range(15, 35),
                                        $urandom_range(15, 35));
        endcase
        return word;
    endfunction

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= WatchdogLimit)
        begin
            $display("FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        stall_cycles = 0;
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // ANSI pass-through, cube corners, grey ramp ends, saturation
        send_word(make_index(0), 0);
        send_word(make_index(7), 1);
        send_word(make_index(15), 0);
        send_word(make_index(16), 0);
        send_word(make_index(100), 2);
        send_word(make_index(231), 0);
        send_word(make_index(232), 0);
        send_word(make_index(244), 0);
        send_word(make_index(255), 3);
        send_word(make_index(256), 0);
        send_word(make_index(16'h8000), 0);
        send_word(make_index(16'hffff), 0);
        // truecolor extremes, exact entries and a black/dark grey tie
        send_word(make_rgb(0, 0, 0), 0);
        send_word(make_rgb(255, 255, 255), 0);
        send_word(make_rgb(25, 26, 25), 1);
        send_word(make_rgb(0, 136, 255), 0);
        send_word(make_rgb(255, 0, 0), 0);
        send_word(make_rgb(0, 255, 0), 0);
        send_word(make_rgb(0, 0, 255), 4);
        send_word(make_rgb(128, 128, 128), 0);
        send_word(make_rgb(170, 255, 102), 0);
        send_word(make_rgb(255, 255, 0), 0);

        for (int i = 0; i < RandomWords; i++)
            send_word(random_word(), pick_gap(i < RandomWords - SteadyTail));

        @(negedge clk) start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/xc2p16_pkg.sv
rtl/xterm_colour_to_palette16.sv
bench/palette16_result_checker.sv
bench/xterm_colour_to_palette16_test.sv
